// ===== sv/pbtd_pkg.sv =====
// Shared types and constants for the tail-drop packet buffer.
package pbtd_pkg;

    localparam int TIME_W = 33;
    localparam int ARR_W  = 32;
    localparam int PROC_W = 16;
    localparam int CAP_W  = 9;

    localparam logic [CAP_W-1:0]  CAP_RESET = 9'd256;
    localparam logic [TIME_W-1:0] TIME_MAX  = {TIME_W{1'b1}};

    typedef logic [TIME_W-1:0] t_time;
    typedef logic [ARR_W-1:0]  t_arrival;
    typedef logic [PROC_W-1:0] t_proc;
    typedef logic [CAP_W-1:0]  t_cap;

    // Control broadcast to every cell of the finish-time row.
    typedef struct packed {
        logic  shift;
        logic  push;
        t_time data;
    } t_cell_ctl;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

endpackage

// ===== sv/pbtd_in_if.sv =====
// Input channel carrying one packet item.
interface pbtd_in_if;
    import pbtd_pkg::*;

    logic     valid;
    logic     ready;
    t_arrival arr_tick;
    t_proc    proc_ticks;

    modport source (output valid, output arr_tick, output proc_ticks, input ready);
    modport sink   (input valid, input arr_tick, input proc_ticks, output ready);
endinterface

// ===== sv/pbtd_out_if.sv =====
// Output channel carrying one result item.
interface pbtd_out_if;
    import pbtd_pkg::*;

    logic  valid;
    logic  ready;
    logic  dropped;
    t_time start_tick;

    modport source (output valid, output dropped, output start_tick, input ready);
    modport sink   (input valid, input dropped, input start_tick, output ready);
endinterface

// ===== sv/pbtd_cfg_if.sv =====
// Configuration write channel for the queue capacity register.
interface pbtd_cfg_if;
    import pbtd_pkg::*;

    logic valid;
    logic ready;
    t_cap queue_capacity;

    modport source (output valid, output queue_capacity, input ready);
    modport sink   (input valid, input queue_capacity, output ready);
endinterface

// ===== sv/pbtd_cell.sv =====
// One slot of the finish-time row: shifts toward the head or takes a push.
module pbtd_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pbtd_pkg::t_cell_ctl i_ctl,
    input  logic              i_prev_valid,
    input  logic              i_next_valid,
    input  pbtd_pkg::t_time   i_next_finish,
    output logic              o_valid,
    output pbtd_pkg::t_time   o_finish
);
    import pbtd_pkg::*;

    logic  r_valid;
    t_time r_finish;
    logic  n_valid;
    t_time n_finish;
    logic  w_load;

    // The first empty slot behind a full one takes the pushed finish time.
    assign w_load = i_ctl.push && !r_valid && i_prev_valid;

    always_comb begin
        n_valid  = r_valid;
        n_finish = r_finish;
        if (i_ctl.shift) begin
            n_valid  = i_next_valid;
            n_finish = i_next_finish;
        end else if (w_load) begin
            n_valid  = 1'b1;
            n_finish = i_ctl.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_finish <= n_finish;
    end

    assign o_valid  = r_valid;
    assign o_finish = r_finish;
endmodule

// ===== sv/packet_buffer_tail_drop.sv =====
// Top level: tail-drop packet buffer built on a row of finish-time cells.
// Flow: an accepted item is registered, entries whose finish time is not after its
//   arrival are retired from the head one per cycle, and the result is registered
//   once the receiver has taken the previous one. A new item is accepted only after
//   the result is registered, also while that result waits for the receiver.
// Reset clears the cell valid bits, occupancy, last finish time and sets the
//   capacity to 256; cell payloads are not cleared and no clearing pass runs.
module packet_buffer_tail_drop #(
    parameter int DEPTH = 256
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    pbtd_in_if.sink    i_in,
    pbtd_cfg_if.sink   i_cfg,
    pbtd_out_if.source o_out
);
    import pbtd_pkg::*;

    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;
    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

    t_state          r_state;
    t_state          n_state;
    t_arrival        r_arrival;
    t_proc           r_proc;
    logic [OCC_W-1:0] r_occ;
    logic [OCC_W-1:0] n_occ;
    t_time           r_last_finish;
    t_cap            r_cap;
    logic            r_out_valid;
    logic            r_out_dropped;
    t_time           r_out_start;

    logic            cell_valid  [DEPTH];
    t_time           cell_finish [DEPTH];
    t_cell_ctl       w_ctl;

    logic            w_in_ready;
    logic            w_retire;
    logic            w_decide;
    logic            w_drop;
    t_time           w_start;
    logic [TIME_W:0] w_sum;
    t_time           w_finish;
    logic [CMP_W-1:0] w_cap_ext;
    logic [CMP_W-1:0] w_cap_eff;
    logic [CMP_W-1:0] w_occ_ext;

    assign i_cfg.ready = 1'b1;

    // Capacity saturates at the number of cells.
    assign w_cap_ext = CMP_W'(r_cap);
    assign w_cap_eff = (w_cap_ext > DEPTH_C) ? DEPTH_C : w_cap_ext;
    assign w_occ_ext = CMP_W'(r_occ);

    assign w_drop  = (r_occ != '0) && !(w_occ_ext < w_cap_eff);
    assign w_start = (r_occ == '0) ? TIME_W'(r_arrival) : r_last_finish;
    assign w_sum   = {1'b0, w_start} + (TIME_W + 1)'(r_proc);
    assign w_finish = w_sum[TIME_W] ? TIME_MAX : w_sum[TIME_W-1:0];

    // FSM outputs.
    always_comb begin
        w_in_ready = 1'b0;
        w_retire   = 1'b0;
        w_decide   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                w_in_ready = 1'b1;
            end
            ST_RUN: begin
                w_retire = cell_valid[0] && (TIME_W'(r_arrival) >= cell_finish[0]);
                w_decide = !w_retire && (!r_out_valid || o_out.ready);
            end
            default: begin
                w_in_ready = 1'b0;
            end
        endcase
    end

    // FSM next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (w_decide) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign i_in.ready = w_in_ready;

    assign w_ctl.shift = w_retire;
    assign w_ctl.push  = w_decide && !w_drop;
    assign w_ctl.data  = w_finish;

    always_comb begin
        n_occ = r_occ;
        if (w_retire) begin
            n_occ = r_occ - OCC_W'(1);
        end else if (w_ctl.push) begin
            n_occ = r_occ + OCC_W'(1);
        end
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic  w_prev_valid;
            logic  w_next_valid;
            t_time w_next_finish;

            if (g == 0) begin : g_head
                assign w_prev_valid = 1'b1;
            end else begin : g_body
                assign w_prev_valid = cell_valid[g-1];
            end

            if (g == DEPTH - 1) begin : g_last
                assign w_next_valid  = 1'b0;
                assign w_next_finish = '0;
            end else begin : g_link
                assign w_next_valid  = cell_valid[g+1];
                assign w_next_finish = cell_finish[g+1];
            end

            pbtd_cell u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctl         (w_ctl),
                .i_prev_valid  (w_prev_valid),
                .i_next_valid  (w_next_valid),
                .i_next_finish (w_next_finish),
                .o_valid       (cell_valid[g]),
                .o_finish      (cell_finish[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_occ         <= '0;
            r_last_finish <= '0;
            r_cap         <= CAP_RESET;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
            if (i_cfg.valid) begin
                r_cap <= i_cfg.queue_capacity;
            end
            if (w_ctl.push) begin
                r_last_finish <= w_finish;
            end
            if (w_decide) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_in.valid) begin
            r_arrival <= i_in.arr_tick;
            r_proc    <= i_in.proc_ticks;
        end
        if (w_decide) begin
            r_out_dropped <= w_drop;
            r_out_start   <= w_drop ? '0 : w_start;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.dropped    = r_out_dropped;
    assign o_out.start_tick = r_out_start;
endmodule

// ===== sim/packet_buffer_tail_drop_test.sv =====
// Self-checking testbench for the tail-drop packet buffer: directed cases, random traffic.
module packet_buffer_tail_drop_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pbtd_pkg::*;

    localparam int BUFFER_DEPTH = 256;
    localparam int HOLD_CYCLES = 400;
    localparam int QUIET_LIMIT = 4000;
    localparam int TAIL_CYCLES = BUFFER_DEPTH + 40;
    localparam logic [31:0] JUMP_CEILING = 32'hE000_0000;

    typedef struct {
        logic  dropped;
        t_time start_tick;
    } t_verdict;

    // Tracks the finish-time queue and holds the results still owed by the block.
    class drop_tracker;
        t_time       finish_times[$];
        t_verdict    owed[$];
        t_time       last_finish;
        int unsigned capacity;
        int unsigned mismatches;

        function new();
            last_finish = '0;
            capacity = BUFFER_DEPTH;
            mismatches = 0;
        endfunction

        function void set_capacity(t_cap value);
            capacity = (value > BUFFER_DEPTH) ? BUFFER_DEPTH : value;
        endfunction

        function void note_packet(t_arrival arrival, t_proc proc);
            logic [TIME_W:0] finish;
            t_verdict v;
            while (finish_times.size() > 0 && {1'b0, arrival} >= finish_times[0]) begin
                void'(finish_times.pop_front());
            end
            v.dropped = 1'b0;
            if (finish_times.size() == 0) begin
                v.start_tick = {1'b0, arrival};
            end else if (finish_times.size() < capacity) begin
                v.start_tick = last_finish;
            end else begin
                v.dropped = 1'b1;
                v.start_tick = '0;
            end
            if (!v.dropped) begin
                finish = v.start_tick;
                finish = finish + proc;
                last_finish = (finish > TIME_MAX) ? TIME_MAX : finish[TIME_W-1:0];
                finish_times = {finish_times, last_finish};
            end
            owed = {owed, v};
        endfunction

        function void check_result(logic dropped, t_time start_tick);
            t_verdict v;
            if (owed.size() == 0) begin
                $error("result with nothing owed: dropped %0d start_tick %0d",
                       dropped, start_tick);
                mismatches++;
            end else begin
                v = owed.pop_front();
                if (dropped !== v.dropped) begin
                    $error("dropped: expected %0d, actual %0d", v.dropped, dropped);
                    mismatches++;
                end
                if (start_tick !== v.start_tick) begin
                    $error("start_tick: expected %0d, actual %0d", v.start_tick, start_tick);
                    mismatches++;
                end
            end
        endfunction

        function int unsigned faults();
            if (owed.size() != 0) begin
                $error("%0d results never arrived", owed.size());
                mismatches += owed.size();
            end
            return mismatches;
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    pbtd_in_if  in_ch();
    pbtd_cfg_if cfg_ch();
    pbtd_out_if out_ch();

    packet_buffer_tail_drop #(
        .DEPTH(BUFFER_DEPTH)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .i_cfg  (cfg_ch),
        .o_out  (out_ch)
    );

    drop_tracker tracker;
    logic [31:0] wall_time;
    int          sent_count;
    int          taken_count;
    bit          hold_request;
    int          quiet_cycles;

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Every fourth stretch of 40 items runs with no idling at all.
    function automatic int draw_wait(int serial);
        return ((serial / 40) % 4 == 1) ? 0 : $urandom_range(0, 7);
    endfunction

    task automatic send_packet(input t_arrival arrival, input t_proc proc);
        int gap;
        gap = draw_wait(sent_count);
        repeat (gap) begin
            @(negedge i_clk);
            in_ch.valid = 1'b0;
        end
        @(negedge i_clk);
        in_ch.valid = 1'b1;
        in_ch.arr_tick = arrival;
        in_ch.proc_ticks = proc;
        do @(posedge i_clk); while (!in_ch.ready);
        tracker.note_packet(arrival, proc);
        sent_count++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (tracker.owed.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_capacity(input t_cap value);
        wait_drained();
        @(negedge i_clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.queue_capacity = value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        tracker.set_capacity(value);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Back-to-back arrivals fill the buffer to its limit; the receiver stalls early on.
    task automatic run_fill(input int count);
        for (int i = 0; i < count; i++) begin
            if (i == 20) hold_request = 1'b1;
            send_packet(wall_time, t_proc'($urandom_range(1, 65535)));
            wall_time += $urandom_range(0, 3);
        end
        wall_time += 32'h0100_0000;
    endtask

    task automatic run_mixed(input int count);
        int       mode;
        int       pick;
        t_proc    proc;
        t_arrival arrival;
        for (int i = 0; i < count; i++) begin
            mode = $urandom_range(0, 2);
            if (mode == 0) proc = $urandom_range(0, 15);
            else if (mode == 1) proc = $urandom_range(0, 1023);
            else proc = $urandom_range(0, 65535);
            pick = $urandom_range(0, 15);
            if (pick < 8) begin
                wall_time += $urandom_range(0, proc / 2);
            end else if (pick < 14) begin
                wall_time += $urandom_range(0, 2 * proc + 1);
            end else if (pick == 14 && wall_time < JUMP_CEILING) begin
                wall_time += $urandom_range(0, 32'h1000_0000);
            end
            arrival = wall_time;
            // A late item arrives before the previous one.
            if (pick == 15)
                arrival = wall_time - $urandom_range(0, (wall_time < 4096) ? wall_time : 4096);
            send_packet(arrival, proc);
        end
    endtask

    initial begin
        tracker = new();
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.arr_tick = '0;
        in_ch.proc_ticks = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.queue_capacity = '0;
        wall_time = 32'd400000;
        sent_count = 0;
        hold_request = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset capacity: empty buffer, long service, late arrival, retiring two at once.
        send_packet(32'd0, 16'd0);
        send_packet(32'd0, 16'hFFFF);
        send_packet(32'd10, 16'd5);
        send_packet(32'd3, 16'd7);
        send_packet(32'd65540, 16'd0);
        send_packet(32'd65547, 16'd1);

        // With capacity zero only a packet that finds the buffer empty gets in.
        write_capacity(t_cap'(0));
        send_packet(32'd100000, 16'd500);
        send_packet(32'd100001, 16'd1);
        send_packet(32'd100500, 16'd2);

        write_capacity(t_cap'(1));
        send_packet(32'd200000, 16'd10);
        send_packet(32'd200005, 16'd3);
        send_packet(32'd200010, 16'd3);

        write_capacity(t_cap'(2));
        send_packet(32'd300000, 16'd10);
        send_packet(32'd300001, 16'd10);
        send_packet(32'd300002, 16'd10);
        send_packet(32'd300020, 16'd0);

        // Capacity above the store depth saturates at the depth.
        write_capacity(t_cap'(511));
        run_fill(300);

        write_capacity(t_cap'(1));
        run_mixed(70);
        write_capacity(t_cap'(0));
        run_mixed(70);
        write_capacity(t_cap'(256));
        run_mixed(70);
        write_capacity(t_cap'(2));
        run_mixed(70);
        write_capacity(t_cap'($urandom_range(3, 16)));
        run_mixed(70);
        write_capacity(t_cap'(255));
        run_mixed(70);
        write_capacity(t_cap'($urandom_range(17, 200)));
        run_mixed(70);
        write_capacity(t_cap'($urandom_range(257, 510)));
        run_mixed(70);

        // Latest arrival: finish times pass 2^32 and the start tick needs its top bit.
        write_capacity(t_cap'(257));
        send_packet(32'hFFFF_FFFF, 16'hFFFF);
        send_packet(32'hFFFF_FFFF, 16'hFFFF);
        send_packet(32'hFFFF_FFFF, 16'd0);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (tracker.faults() == 0) begin
            $display("PASS packet_buffer_tail_drop");
        end else begin
            $display("FAIL packet_buffer_tail_drop");
        end
        $finish;
    end

    // Result receiver: random stalls, plus one long hold-off on request.
    initial begin
        int stall;
        out_ch.ready = 1'b0;
        taken_count = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                stall = HOLD_CYCLES;
            end else begin
                stall = draw_wait(taken_count);
            end
            repeat (stall) begin
                @(negedge i_clk);
                out_ch.ready = 1'b0;
            end
            @(negedge i_clk);
            out_ch.ready = 1'b1;
            do @(posedge i_clk); while (!(out_ch.valid && out_ch.ready));
            taken_count++;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            tracker.check_result(out_ch.dropped, out_ch.start_tick);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL packet_buffer_tail_drop");
            $finish;
        end
    end

endmodule
